// ----- rtl/core/assert_macros.svh -----
// Assertion macro used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define PKU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- rtl/core/pku_pkg.sv -----
// Shared constants, types and step functions of the particle kinematics unit.
// Depends on nothing.
package pku_pkg;

    localparam int SQ_LAT   = 2;
    localparam int SQRT_LAT = 16;
    localparam int LOG_LAT  = 26;
    localparam int HLN_LAT  = LOG_LAT + 4;
    localparam int PIPE_LAT = SQ_LAT + SQRT_LAT + HLN_LAT;

    localparam logic [30:0] MASS_RESET = 31'd65536;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [22:0] OUT_MAX    = 23'h3FFFFF;
    localparam logic [22:0] OUT_MIN    = 23'h400000;

    typedef enum logic [1:0] {
        RC_NORMAL,
        RC_BOTH,
        RC_DEN,
        RC_NUM
    } ratio_case_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] root;
        logic [63:0] rest;
    } sqrt_state_t;

    // one bit of a restoring square root
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
        sqrt_state_t r;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        rem_sh = {s.rem[33:0], s.rest[63:62]};
        trial  = {2'b00, s.root, 2'b01};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[30:0], 1'b0};
        end
        r.rest = {s.rest[61:0], 2'b00};
        return r;
    endfunction

    function automatic logic [5:0] top_index(input logic [32:0] x);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (x[i])
                n = 6'(i);
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/pku_sqrt_pipe.sv -----
// Pipelined floor square root of a 64-bit value, two root bits per stage.
// Depends on pku_pkg.
module pku_sqrt_pipe (
    input  logic        clk,
    input  logic        adv,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import pku_pkg::*;

    sqrt_state_t st_reg [SQRT_LAT];

    for (genvar g = 0; g < SQRT_LAT; g++)
    begin : g_stage
        sqrt_state_t src;
        sqrt_state_t st_next;
        if (g == 0)
        begin : g_first
            assign src = '{rem: '0, root: '0, rest: radicand};
        end
        else
        begin : g_rest
            assign src = st_reg[g-1];
        end
        assign st_next = sqrt_step(sqrt_step(src));
        always_ff @(posedge clk)
        begin
            if (adv)
                st_reg[g] <= st_next;
        end
    end

    assign root = st_reg[SQRT_LAT-1].root;

endmodule

// ----- rtl/core/pku_log2_pipe.sv -----
// Pipelined log2 with 24 fraction bits: normalize, then one squaring per stage.
// Depends on pku_pkg.
module pku_log2_pipe (
    input  logic        clk,
    input  logic        adv,
    input  logic [32:0] x,
    output logic [29:0] log_val
);
    import pku_pkg::*;

    localparam int FRAC = 24;

    logic [32:0] x_reg;
    logic [5:0]  n0_reg;
    logic [31:0] m_reg    [FRAC+1];
    logic [5:0]  n_reg    [FRAC+1];
    logic [23:0] frac_reg [FRAC+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg       <= x;
            n0_reg      <= top_index(x);
            m_reg[0]    <= 32'({x_reg, 31'd0} >> n0_reg);
            n_reg[0]    <= n0_reg;
            frac_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= FRAC; k++)
    begin : g_sq
        logic [63:0] prod;
        assign prod = 64'(m_reg[k-1]) * 64'(m_reg[k-1]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[k]    <= prod[63] ? prod[63:32] : prod[62:31];
                n_reg[k]    <= n_reg[k-1];
                frac_reg[k] <= {frac_reg[k-1][22:0], prod[63]};
            end
        end
    end

    assign log_val = {n_reg[FRAC], frac_reg[FRAC]};

endmodule

// ----- rtl/core/pku_half_ln.sv -----
// Half natural log of (a+pz)/(a-pz) with saturation and clip flag.
// Depends on pku_pkg, pku_log2_pipe.
module pku_half_ln (
    input  logic               clk,
    input  logic               adv,
    input  logic [31:0]        a,
    input  logic signed [31:0] pz,
    output logic [22:0]        value,
    output logic               clip
);
    import pku_pkg::*;

    localparam int CDEPTH = LOG_LAT + 3;

    logic signed [33:0] num_next;
    logic signed [33:0] den_next;
    ratio_case_t        case_next;
    logic [32:0]        num_reg;
    logic [32:0]        den_reg;
    ratio_case_t        case_reg [CDEPTH];
    logic [29:0]        la;
    logic [29:0]        lb;
    logic               neg_reg;
    logic [29:0]        d_reg;
    logic               neg2_reg;
    logic [59:0]        prod_reg;
    logic [60:0]        rnd;
    logic [23:0]        q;
    logic [22:0]        value_next;
    logic               clip_next;
    logic [22:0]        value_reg;
    logic               clip_reg;

    always_comb
    begin
        num_next = $signed({2'b00, a}) + 34'(pz);
        den_next = $signed({2'b00, a}) - 34'(pz);
        if ((num_next <= 0) && (den_next <= 0))
            case_next = RC_BOTH;
        else if (den_next <= 0)
            case_next = RC_DEN;
        else if (num_next <= 0)
            case_next = RC_NUM;
        else
            case_next = RC_NORMAL;
    end

    pku_log2_pipe u_log_num (.clk(clk), .adv(adv), .x(num_reg), .log_val(la));
    pku_log2_pipe u_log_den (.clk(clk), .adv(adv), .x(den_reg), .log_val(lb));

    always_comb
    begin
        rnd = {1'b0, prod_reg} + (61'd1 << 38);
        q   = 24'(rnd[60:39]);
        value_next = neg2_reg ? 23'(-q) : q[22:0];
        clip_next  = 1'b0;
        if (!neg2_reg && q > 24'(OUT_MAX))
        begin
            value_next = OUT_MAX;
            clip_next  = 1'b1;
        end
        if (neg2_reg && q > 24'(OUT_MIN))
        begin
            value_next = OUT_MIN;
            clip_next  = 1'b1;
        end
        case (case_reg[CDEPTH-1])
            RC_BOTH:
            begin
                value_next = '0;
                clip_next  = 1'b1;
            end
            RC_DEN:
            begin
                value_next = OUT_MAX;
                clip_next  = 1'b1;
            end
            RC_NUM:
            begin
                value_next = OUT_MIN;
                clip_next  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg     <= num_next[32:0];
            den_reg     <= den_next[32:0];
            case_reg[0] <= case_next;
            for (int i = 1; i < CDEPTH; i++)
                case_reg[i] <= case_reg[i-1];
            neg_reg   <= la < lb;
            d_reg     <= (la < lb) ? (lb - la) : (la - lb);
            neg2_reg  <= neg_reg;
            prod_reg  <= 60'(d_reg) * 60'(LN2_Q30);
            value_reg <= value_next;
            clip_reg  <= clip_next;
        end
    end

    assign value = value_reg;
    assign clip  = clip_reg;

endmodule

// ----- rtl/core/particle_kinematics_unit.sv -----
// Top level: momentum, energy, rapidity and pseudorapidity of one track per beat.
// Depends on pku_pkg, pku_sqrt_pipe, pku_half_ln.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | mom_x, mom_y, mom_z
//  out     | out | out_valid / out_ready | total_energy, mom_magnitude, rapidity_out,
//          |     |                       | pseudorapidity_out, rapidity_clipped, eta_clipped
//  cfg     | in  | cfg_we                | cfg_data (particle mass)
//
// One beat per cycle unless out stalls; 2 square/sum, 16 square root, 30 log stages.
// The whole pipe advances together; a stalled output freezes every stage.
// Reset clears the valid bits and loads a mass of 1.0 GeV.
module particle_kinematics_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] mom_x,
    input  logic signed [31:0] mom_y,
    input  logic signed [31:0] mom_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [32:0]        total_energy,
    output logic [31:0]        mom_magnitude,
    output logic signed [22:0] rapidity_out,
    output logic signed [22:0] pseudorapidity_out,
    output logic               rapidity_clipped,
    output logic               eta_clipped
);
    import pku_pkg::*;

    localparam int PZ_DEPTH = SQ_LAT + SQRT_LAT;

    logic                adv;
    logic [30:0]         mass_reg;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [31:0]         ax;
    logic [31:0]         ay;
    logic [31:0]         az;
    logic [63:0]         sqx_reg;
    logic [63:0]         sqy_reg;
    logic [63:0]         sqz_reg;
    logic [61:0]         sqm_reg;
    logic [63:0]         p2_reg;
    logic [63:0]         e2_reg;
    logic signed [31:0]  pz_reg [PZ_DEPTH];
    logic [31:0]         p_root;
    logic [31:0]         e_root;
    logic [31:0]         p_reg  [HLN_LAT];
    logic [31:0]         e_reg  [HLN_LAT];

    assign adv      = !vld_reg[PIPE_LAT-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg <= MASS_RESET;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                mass_reg <= cfg_data;
            if (adv)
                vld_reg <= {vld_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    assign ax = mom_x[31] ? 32'(-mom_x) : 32'(mom_x);
    assign ay = mom_y[31] ? 32'(-mom_y) : 32'(mom_y);
    assign az = mom_z[31] ? 32'(-mom_z) : 32'(mom_z);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg   <= 64'(ax) * 64'(ax);
            sqy_reg   <= 64'(ay) * 64'(ay);
            sqz_reg   <= 64'(az) * 64'(az);
            sqm_reg   <= 62'(mass_reg) * 62'(mass_reg);
            pz_reg[0] <= mom_z;
            for (int i = 1; i < PZ_DEPTH; i++)
                pz_reg[i] <= pz_reg[i-1];
            p2_reg <= sqx_reg + sqy_reg + sqz_reg;
            e2_reg <= sqx_reg + sqy_reg + sqz_reg + 64'(sqm_reg);
            p_reg[0] <= p_root;
            e_reg[0] <= e_root;
            for (int i = 1; i < HLN_LAT; i++)
            begin
                p_reg[i] <= p_reg[i-1];
                e_reg[i] <= e_reg[i-1];
            end
        end
    end

    pku_sqrt_pipe u_sqrt_p (.clk(clk), .adv(adv), .radicand(p2_reg), .root(p_root));
    pku_sqrt_pipe u_sqrt_e (.clk(clk), .adv(adv), .radicand(e2_reg), .root(e_root));

    pku_half_ln u_rap (
        .clk   (clk),
        .adv   (adv),
        .a     (e_root),
        .pz    (pz_reg[PZ_DEPTH-1]),
        .value (rapidity_out),
        .clip  (rapidity_clipped)
    );

    pku_half_ln u_eta (
        .clk   (clk),
        .adv   (adv),
        .a     (p_root),
        .pz    (pz_reg[PZ_DEPTH-1]),
        .value (pseudorapidity_out),
        .clip  (eta_clipped)
    );

    assign out_valid     = vld_reg[PIPE_LAT-1];
    assign total_energy  = {1'b0, e_reg[HLN_LAT-1]};
    assign mom_magnitude = p_reg[HLN_LAT-1];

endmodule

// ----- rtl/core/pku_checker.sv -----
// Port-level checks of the particle kinematics unit, bound to the top level.
// Depends on assert_macros.svh.
module pku_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] mom_magnitude,
    input logic        eta_clipped
);
    `include "assert_macros.svh"

    `PKU_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out beat dropped")
    `PKU_ASSERT(a_ready, clk, rst_n, in_ready == (!out_valid || out_ready), "in_ready mismatch")
    `PKU_ASSERT(a_zero_p, clk, rst_n, out_valid && mom_magnitude == 0 |-> eta_clipped, "eta not clipped")
    `PKU_ASSERT(a_fall, clk, rst_n, $fell(out_valid) |-> $past(out_ready), "out beat lost")

endmodule

bind particle_kinematics_unit pku_checker u_pku_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for particle_kinematics_unit: drives momentum beats, predicts
// energy, momentum magnitude, rapidity and pseudorapidity, and checks every result beat.
// Depends on pku_pkg and the particle_kinematics_unit RTL.
`timescale 1ns / 100ps

class kin_scoreboard;
    typedef struct {
        logic [32:0] energy;
        logic [31:0] pmag;
        logic [22:0] rap;
        logic [22:0] eta;
        logic        rap_clip;
        logic        eta_clip;
    } kin_result_t;

    kin_result_t pending[$];
    logic [30:0] mass;
    int          errors;

    function new();
        mass   = pku_pkg::MASS_RESET;
        errors = 0;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_q24(input logic [63:0] x);
        int          n;
        logic [63:0] m;
        logic [63:0] r;
        logic [127:0] sq;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (x[i])
                n = i;
        m = (n <= 31) ? (x << (31 - n)) : (x >> (n - 31));
        r = 64'(n) << 24;
        for (int i = 23; i >= 0; i--)
        begin
            sq = 128'(m) * 128'(m);
            m  = 64'(sq >> 31);
            if (m >= (64'd1 << 32))
            begin
                m    = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [22:0] half_ln(input longint num, input longint den,
                                            output logic clip);
        logic [63:0]  la;
        logic [63:0]  lb;
        logic [63:0]  d;
        logic [127:0] prod;
        logic [63:0]  q;
        logic         neg;
        clip = 1'b0;
        if (num <= 0 && den <= 0)
        begin
            clip = 1'b1;
            return '0;
        end
        if (den <= 0)
        begin
            clip = 1'b1;
            return pku_pkg::OUT_MAX;
        end
        if (num <= 0)
        begin
            clip = 1'b1;
            return pku_pkg::OUT_MIN;
        end
        la   = log2_q24(64'(num));
        lb   = log2_q24(64'(den));
        neg  = la < lb;
        d    = neg ? lb - la : la - lb;
        prod = 128'(d) * 128'(pku_pkg::LN2_Q30) + (128'd1 << 38);
        q    = 64'(prod >> 39);
        if (!neg && q > 64'h3FFFFF)
        begin
            clip = 1'b1;
            q    = 64'h3FFFFF;
        end
        if (neg && q > 64'h400000)
        begin
            clip = 1'b1;
            q    = 64'h400000;
        end
        return neg ? 23'(64'd0 - q) : 23'(q);
    endfunction

    function void note_track(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] pz);
        kin_result_t r;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] az;
        logic [63:0] p2;
        logic [63:0] e2;
        longint      p;
        longint      e;
        longint      z;
        z  = longint'(pz);
        ax = 64'(px < 0 ? -longint'(px) : longint'(px));
        ay = 64'(py < 0 ? -longint'(py) : longint'(py));
        az = 64'(z < 0 ? -z : z);
        p2 = ax * ax + ay * ay + az * az;
        e2 = p2 + 64'(mass) * 64'(mass);
        p  = longint'(isqrt(p2));
        e  = longint'(isqrt(e2));
        r.rap    = half_ln(e + z, e - z, r.rap_clip);
        r.eta    = half_ln(p + z, p - z, r.eta_clip);
        r.energy = 33'(e);
        r.pmag   = 32'(p);
        pending.push_back(r);
    endfunction

    function void check_result(input logic [32:0] en, input logic [31:0] pm,
                               input logic [22:0] ra, input logic [22:0] et,
                               input logic rc, input logic ec);
        kin_result_t r;
        if (pending.size() == 0)
        begin
            $error("unexpected result beat");
            errors++;
            return;
        end
        r = pending.pop_front();
        if (en !== r.energy)
        begin
            $error("total_energy exp %0d got %0d", r.energy, en);
            errors++;
        end
        if (pm !== r.pmag)
        begin
            $error("mom_magnitude exp %0d got %0d", r.pmag, pm);
            errors++;
        end
        if (ra !== r.rap)
        begin
            $error("rapidity_out exp %0d got %0d", $signed(r.rap), $signed(ra));
            errors++;
        end
        if (et !== r.eta)
        begin
            $error("pseudorapidity_out exp %0d got %0d", $signed(r.eta), $signed(et));
            errors++;
        end
        if (rc !== r.rap_clip)
        begin
            $error("rapidity_clipped exp %0d got %0d", r.rap_clip, rc);
            errors++;
        end
        if (ec !== r.eta_clip)
        begin
            $error("eta_clipped exp %0d got %0d", r.eta_clip, ec);
            errors++;
        end
    endfunction
endclass

module tb;
    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic               out_valid;
    logic               out_ready;
    logic [32:0]        total_energy;
    logic [31:0]        mom_magnitude;
    logic signed [22:0] rapidity_out;
    logic signed [22:0] pseudorapidity_out;
    logic               rapidity_clipped;
    logic               eta_clipped;

    kin_scoreboard sb;
    bit            quiet;
    bit            hold_sink;
    bit            sink_hold_done;
    int            idle_cycles = 0;

    particle_kinematics_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .total_energy(total_energy), .mom_magnitude(mom_magnitude),
        .rapidity_out(rapidity_out), .pseudorapidity_out(pseudorapidity_out),
        .rapidity_clipped(rapidity_clipped), .eta_clipped(eta_clipped)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_track(mom_x, mom_y, mom_z);
            if (out_valid && out_ready)
                sb.check_result(total_energy, mom_magnitude, rapidity_out,
                                pseudorapidity_out, rapidity_clipped, eta_clipped);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000)
            begin
                $display("[particle_kinematics_unit] ERROR");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink && !sink_hold_done)
            begin
                out_ready <= 1'b0;
                for (n = 0; n < 300; n++)
                    @(posedge clk);
                sink_hold_done = 1'b1;
            end
            out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
        end
    end

    task automatic send_track(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        while (!quiet && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mom_x    <= x;
        mom_y    <= y;
        mom_z    <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (pku_pkg::PIPE_LAT + 8) @(posedge clk);
    endtask

    task automatic set_mass(input logic [30:0] m);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.mass = m;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_mom(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return 32'($signed($urandom_range(64)) - 32);
            default: return ($urandom_range(1)) ? 32'h7FFFFFFF - $urandom_range(255)
                                                : 32'h80000000 + $urandom_range(255);
        endcase
    endfunction

    initial
    begin
        logic [30:0] masses[5];
        int          k;
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        mom_x     = '0;
        mom_y     = '0;
        mom_z     = '0;
        quiet     = 1'b0;
        hold_sink = 1'b0;
        masses = '{31'd65536, 31'd0, 31'h7FFFFFFF, 31'd9150, 31'd61669};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes and saturation cases at reset mass, zero mass and maximum mass
        send_track(0, 0, 0);
        send_track(0, 0, 32'h00010000);
        send_track(0, 0, 32'hFFFF0000);
        send_track(1, 0, 32'h00100000);
        send_track(0, 1, 32'hFFF00000);
        send_track(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_track(32'h80000000, 32'h80000000, 32'h80000000);
        send_track(32'h80000000, 0, 32'h7FFFFFFF);
        send_track(0, 0, 32'h80000000);
        send_track(0, 0, 32'h7FFFFFFF);
        send_track(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_track(32'h00008000, 32'hFFFF8000, 32'h00020000);
        drain();
        set_mass(0);
        send_track(0, 0, 0);
        send_track(0, 0, 32'h00050000);
        send_track(0, 0, 32'hFFFB0000);
        send_track(3, 0, 32'h40000000);
        send_track(32'h00010000, 32'h00010000, 0);
        drain();
        set_mass(31'h7FFFFFFF);
        send_track(0, 0, 0);
        send_track(0, 0, 32'h7FFFFFFF);
        send_track(32'h7FFFFFFF, 32'h80000000, 32'h80000000);
        drain();
        // random phases over several masses
        for (int ph = 0; ph < 5; ph++)
        begin
            set_mass(ph == 4 ? 31'($urandom()) : masses[ph]);
            quiet = (ph == 2);
            if (ph == 1)
                hold_sink = 1'b1;
            for (int i = 0; i < 340; i++)
            begin
                k = $urandom_range(9);
                send_track(rand_mom(k < 4 ? 0 : k < 7 ? 1 : k < 8 ? 2 : 3),
                           (k == 9) ? 32'($urandom_range(2)) : rand_mom(k % 4),
                           rand_mom(k < 5 ? 0 : k % 4));
                if (ph == 3 && i == 170)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending.size() != 0)
                        @(posedge clk);
                end
            end
            quiet = 1'b0;
            drain();
            while (ph == 1 && !sink_hold_done)
                @(posedge clk);
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[particle_kinematics_unit] OK");
        else
            $display("[particle_kinematics_unit] ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pku_pkg.sv
rtl/core/pku_sqrt_pipe.sv
rtl/core/pku_log2_pipe.sv
rtl/core/pku_half_ln.sv
rtl/core/particle_kinematics_unit.sv
rtl/core/pku_checker.sv
tb/tb.sv
